// ----- rtl/core/qrm_pkg.sv -----
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, types and constants for the quaternion to rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

   // Component and result widths
   localparam int QUAT_W        = 16;
   localparam int ENT_W         = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int NUM_ENT       = 9;

   // Products, numerators, squared norm, divider remainder
   localparam int PROD_W = 2 * QUAT_W;
   localparam int NUM_W  = PROD_W + 2;
   localparam int DEN_W  = PROD_W + 1;
   localparam int MAG_W  = DEN_W;
   localparam int REM_W  = DEN_W + 1;

   // Quotient keeps one extra bit below the output LSB for rounding,
   // one above for the full-scale value
   localparam int QUO_W = OUT_FRAC_BITS + 2;

   // Accept edge to the edge at which the result is taken
   localparam int LATENCY = QUO_W + 3;

   // Full-scale magnitude (plus or minus one)
   localparam int ONE = 1 << OUT_FRAC_BITS;

   // Matrix entry order
   localparam int E_M00 = 0;
   localparam int E_M01 = 1;
   localparam int E_M02 = 2;
   localparam int E_M10 = 3;
   localparam int E_M11 = 4;
   localparam int E_M12 = 5;
   localparam int E_M20 = 6;
   localparam int E_M21 = 7;
   localparam int E_M22 = 8;

   typedef logic signed [QUAT_W-1:0] qrm_quat_type;
   typedef logic signed [ENT_W-1:0] qrm_ent_type;
   typedef logic [NUM_ENT-1:0][REM_W-1:0] qrm_rem_vec_type;
   typedef logic [NUM_ENT-1:0][QUO_W-1:0] qrm_quo_vec_type;

   // Control traveling with each request through the divider chain
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic [NUM_ENT-1:0] neg;
   } qrm_ctl_type;

endpackage

// ----- rtl/core/qrm_div_stage.sv -----
// ----------------------------------------------------------------------------
// qrm_div_stage
// One registered restoring-division step for all nine matrix entries: each
// lane compares its partial remainder against the shared squared norm,
// subtracts when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module qrm_div_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  qrm_pkg::qrm_ctl_type     up_ctl,
   input  logic [qrm_pkg::DEN_W-1:0] up_den,
   input  qrm_pkg::qrm_rem_vec_type up_rem,
   input  qrm_pkg::qrm_quo_vec_type up_quo,
   output qrm_pkg::qrm_ctl_type     dn_ctl,
   output logic [qrm_pkg::DEN_W-1:0] dn_den,
   output qrm_pkg::qrm_rem_vec_type dn_rem,
   output qrm_pkg::qrm_quo_vec_type dn_quo
);
   import qrm_pkg::*;

   logic [NUM_ENT-1:0][REM_W:0] diff;
   logic [NUM_ENT-1:0]          take;

   qrm_ctl_type       ctl_ff;
   logic [DEN_W-1:0]  den_ff;
   qrm_rem_vec_type   rem_ff, rem_in;
   qrm_quo_vec_type   quo_ff, quo_in;

   // Trial subtract per lane; remainder stays below the norm, so the
   // doubled value always fits
   always_comb begin
      for (int e = 0; e < NUM_ENT; e++) begin
         diff[e]   = {1'b0, up_rem[e]} - {2'b00, up_den};
         take[e]   = ~diff[e][REM_W];
         rem_in[e] = take[e] ? {diff[e][REM_W-2:0], 1'b0}
                             : {up_rem[e][REM_W-2:0], 1'b0};
         quo_in[e] = {up_quo[e][QUO_W-2:0], take[e]};
      end
   end

   // Control: only the valid bit is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= up_ctl.valid;
      end
      ctl_ff.zero <= up_ctl.zero;
      ctl_ff.neg  <= up_ctl.neg;
   end

   // Payload
   always_ff @(posedge clock) begin
      den_ff      <= up_den;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
   end

   assign dn_ctl = ctl_ff;
   assign dn_den = den_ff;
   assign dn_rem = rem_ff;
   assign dn_quo = quo_ff;

endmodule

// ----- rtl/core/quaternion_to_rotation_matrix_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Quaternion (Q1.15) to 3x3 rotation matrix (Q2.14), divided by the squared
// norm, rounded to nearest and saturated to plus or minus one.
// ----------------------------------------------------------------------------
// Stages from the accept edge to the edge that takes rsp_valid:
//   one product stage, one sum stage, 16 divider steps, one rounding stage.
// Throughput: one request per cycle; the 16-step divider chain is fully
//   pipelined and busy is low whenever reset is low.
// Reset: synchronous, clears all valid bits; no result is issued until
//   requests arrive after reset. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  qrm_pkg::qrm_quat_type req_quat_w,
   input  qrm_pkg::qrm_quat_type req_quat_x,
   input  qrm_pkg::qrm_quat_type req_quat_y,
   input  qrm_pkg::qrm_quat_type req_quat_z,
   output logic                  rsp_valid,
   output qrm_pkg::qrm_ent_type  rsp_m00,
   output qrm_pkg::qrm_ent_type  rsp_m01,
   output qrm_pkg::qrm_ent_type  rsp_m02,
   output qrm_pkg::qrm_ent_type  rsp_m10,
   output qrm_pkg::qrm_ent_type  rsp_m11,
   output qrm_pkg::qrm_ent_type  rsp_m12,
   output qrm_pkg::qrm_ent_type  rsp_m20,
   output qrm_pkg::qrm_ent_type  rsp_m21,
   output qrm_pkg::qrm_ent_type  rsp_m22,
   output logic                  rsp_zero_quat
);
   import qrm_pkg::*;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   // ---------------------------------------------------------------------
   // Stage A: the ten component products
   // ---------------------------------------------------------------------
   logic     valid_a_ff;
   prod_type pww_ff, pxx_ff, pyy_ff, pzz_ff;
   prod_type pxy_ff, pwz_ff, pxz_ff, pwy_ff, pyz_ff, pwx_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      pww_ff <= req_quat_w * req_quat_w;
      pxx_ff <= req_quat_x * req_quat_x;
      pyy_ff <= req_quat_y * req_quat_y;
      pzz_ff <= req_quat_z * req_quat_z;
      pxy_ff <= req_quat_x * req_quat_y;
      pwz_ff <= req_quat_w * req_quat_z;
      pxz_ff <= req_quat_x * req_quat_z;
      pwy_ff <= req_quat_w * req_quat_y;
      pyz_ff <= req_quat_y * req_quat_z;
      pwx_ff <= req_quat_w * req_quat_x;
   end

   // ---------------------------------------------------------------------
   // Stage B: numerators, squared norm, sign and magnitude
   // ---------------------------------------------------------------------
   num_type               sww, sxx, syy, szz, den_sum;
   num_type               num [NUM_ENT];
   num_type               absval [NUM_ENT];
   qrm_ctl_type           ctl_b_ff, ctl_b_in;
   logic [DEN_W-1:0]      den_b_ff;
   qrm_rem_vec_type       rem_b_ff, rem_b_in;

   always_comb begin
      sww     = NUM_W'(pww_ff);
      sxx     = NUM_W'(pxx_ff);
      syy     = NUM_W'(pyy_ff);
      szz     = NUM_W'(pzz_ff);
      den_sum = sww + sxx + syy + szz;

      num[E_M00] = sww + sxx - syy - szz;
      num[E_M11] = sww - sxx + syy - szz;
      num[E_M22] = sww - sxx - syy + szz;
      num[E_M01] = (NUM_W'(pxy_ff) - NUM_W'(pwz_ff)) <<< 1;
      num[E_M10] = (NUM_W'(pxy_ff) + NUM_W'(pwz_ff)) <<< 1;
      num[E_M02] = (NUM_W'(pxz_ff) + NUM_W'(pwy_ff)) <<< 1;
      num[E_M20] = (NUM_W'(pxz_ff) - NUM_W'(pwy_ff)) <<< 1;
      num[E_M12] = (NUM_W'(pyz_ff) - NUM_W'(pwx_ff)) <<< 1;
      num[E_M21] = (NUM_W'(pyz_ff) + NUM_W'(pwx_ff)) <<< 1;

      ctl_b_in.valid = valid_a_ff;
      ctl_b_in.zero  = (den_sum == '0);
      for (int e = 0; e < NUM_ENT; e++) begin
         ctl_b_in.neg[e] = num[e][NUM_W-1];
         absval[e]       = num[e][NUM_W-1] ? -num[e] : num[e];
         rem_b_in[e]     = {1'b0, absval[e][MAG_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
      end else begin
         ctl_b_ff.valid <= ctl_b_in.valid;
      end
      ctl_b_ff.zero <= ctl_b_in.zero;
      ctl_b_ff.neg  <= ctl_b_in.neg;
   end

   always_ff @(posedge clock) begin
      den_b_ff      <= den_sum[DEN_W-1:0];
      rem_b_ff      <= rem_b_in;
   end

   // ---------------------------------------------------------------------
   // Divider chain: one quotient bit per stage, magnitude * 2^(QUO_W-1) / S
   // ---------------------------------------------------------------------
   qrm_ctl_type      ctl_s [QUO_W+1];
   logic [DEN_W-1:0] den_s [QUO_W+1];
   qrm_rem_vec_type  rem_s [QUO_W+1];
   qrm_quo_vec_type  quo_s [QUO_W+1];

   assign ctl_s[0] = ctl_b_ff;
   assign den_s[0] = den_b_ff;
   assign rem_s[0] = rem_b_ff;
   assign quo_s[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      qrm_div_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (ctl_s[k]),
         .up_den (den_s[k]),
         .up_rem (rem_s[k]),
         .up_quo (quo_s[k]),
         .dn_ctl (ctl_s[k+1]),
         .dn_den (den_s[k+1]),
         .dn_rem (rem_s[k+1]),
         .dn_quo (quo_s[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output stage: halve with round-half-up on the magnitude, clamp,
   // apply sign, force zero for a null quaternion
   // ---------------------------------------------------------------------
   logic [QUO_W:0]   rnd_sum [NUM_ENT];
   logic [QUO_W-1:0] rnd_mag [NUM_ENT];
   qrm_ent_type      ent_in [NUM_ENT];
   qrm_ent_type      ent_ff [NUM_ENT];
   logic             valid_o_ff;
   logic             zero_o_ff;
   qrm_ctl_type      ctl_last;

   assign ctl_last = ctl_s[QUO_W];

   always_comb begin
      for (int e = 0; e < NUM_ENT; e++) begin
         rnd_sum[e] = {1'b0, quo_s[QUO_W][e]} + (QUO_W+1)'(1);
         rnd_mag[e] = rnd_sum[e][QUO_W:1];
         if (rnd_mag[e] > QUO_W'(ONE)) begin
            rnd_mag[e] = QUO_W'(ONE);
         end
         if (ctl_last.zero) begin
            ent_in[e] = '0;
         end else if (ctl_last.neg[e]) begin
            ent_in[e] = -ENT_W'(rnd_mag[e]);
         end else begin
            ent_in[e] = ENT_W'(rnd_mag[e]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else begin
         valid_o_ff <= ctl_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      zero_o_ff <= ctl_last.zero;
      ent_ff    <= ent_in;
   end

   assign rsp_valid     = valid_o_ff;
   assign rsp_zero_quat = zero_o_ff;
   assign rsp_m00       = ent_ff[E_M00];
   assign rsp_m01       = ent_ff[E_M01];
   assign rsp_m02       = ent_ff[E_M02];
   assign rsp_m10       = ent_ff[E_M10];
   assign rsp_m11       = ent_ff[E_M11];
   assign rsp_m12       = ent_ff[E_M12];
   assign rsp_m20       = ent_ff[E_M20];
   assign rsp_m21       = ent_ff[E_M21];
   assign rsp_m22       = ent_ff[E_M22];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   function automatic logic ent_ok(input qrm_ent_type m);
      return (m >= -ONE) && (m <= ONE);
   endfunction

   // Every accepted request comes out after exactly the pipeline latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not produce a result on time");

   // No result without a request the pipeline latency earlier
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");

   // A null quaternion gives an all-zero matrix
   a_zero_quat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_quat) |->
         (rsp_m00 == '0 && rsp_m01 == '0 && rsp_m02 == '0 &&
          rsp_m10 == '0 && rsp_m11 == '0 && rsp_m12 == '0 &&
          rsp_m20 == '0 && rsp_m21 == '0 && rsp_m22 == '0))
      else $error("zero quaternion with nonzero entries");

   // All entries within plus or minus one
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (ent_ok(rsp_m00) && ent_ok(rsp_m01) && ent_ok(rsp_m02) &&
          ent_ok(rsp_m10) && ent_ok(rsp_m11) && ent_ok(rsp_m12) &&
          ent_ok(rsp_m20) && ent_ok(rsp_m21) && ent_ok(rsp_m22)))
      else $error("matrix entry out of range");

endmodule

// ----- test/rotation_matrix_checker.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_checker
// Watches the request and result channels of the quaternion to rotation
// matrix block, predicts each matrix from the accepted quaternion and
// compares every entry and the zero flag against the returned result.
// ----------------------------------------------------------------------------
module rotation_matrix_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  qrm_pkg::qrm_quat_type req_quat_w,
   input  qrm_pkg::qrm_quat_type req_quat_x,
   input  qrm_pkg::qrm_quat_type req_quat_y,
   input  qrm_pkg::qrm_quat_type req_quat_z,
   input  logic                  rsp_valid,
   input  qrm_pkg::qrm_ent_type  rsp_m00,
   input  qrm_pkg::qrm_ent_type  rsp_m01,
   input  qrm_pkg::qrm_ent_type  rsp_m02,
   input  qrm_pkg::qrm_ent_type  rsp_m10,
   input  qrm_pkg::qrm_ent_type  rsp_m11,
   input  qrm_pkg::qrm_ent_type  rsp_m12,
   input  qrm_pkg::qrm_ent_type  rsp_m20,
   input  qrm_pkg::qrm_ent_type  rsp_m21,
   input  qrm_pkg::qrm_ent_type  rsp_m22,
   input  logic                  rsp_zero_quat,
   output int                    fail_count,
   output int                    pending,
   output int                    matrices_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import qrm_pkg::*;

   typedef struct {
      qrm_ent_type ent [NUM_ENT];
      logic        zero;
   } rot_matrix_type;

   rot_matrix_type expected_matrices [$];

   // round(num * 2^OUT_FRAC_BITS / den), ties away from zero, clamped to one
   function automatic qrm_ent_type scale_to_q2_14(longint num, longint den);
      logic   neg;
      longint mag;
      longint quo;
      neg = (num < 0);
      mag = neg ? -num : num;
      quo = (2 * (mag <<< OUT_FRAC_BITS) + den) / (2 * den);
      if (quo > ONE)
         quo = ONE;
      if (neg)
         quo = -quo;
      return qrm_ent_type'(quo);
   endfunction

   // Each entry is a quadratic form over the squared norm
   function automatic rot_matrix_type rotation_from_quat(qrm_quat_type qw, qrm_quat_type qx,
                                                        qrm_quat_type qy, qrm_quat_type qz);
      longint         w, x, y, z;
      longint         ww, xx, yy, zz, norm_sq;
      longint         num [NUM_ENT];
      rot_matrix_type m;
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      norm_sq = ww + xx + yy + zz;
      m.zero = (norm_sq == 0);
      if (m.zero) begin
         foreach (m.ent[k]) m.ent[k] = '0;
         return m;
      end
      num[E_M00] = ww + xx - yy - zz;
      num[E_M01] = 2 * (x * y - w * z);
      num[E_M02] = 2 * (x * z + w * y);
      num[E_M10] = 2 * (x * y + w * z);
      num[E_M11] = ww - xx + yy - zz;
      num[E_M12] = 2 * (y * z - w * x);
      num[E_M20] = 2 * (x * z - w * y);
      num[E_M21] = 2 * (y * z + w * x);
      num[E_M22] = ww - xx - yy + zz;
      foreach (num[k]) m.ent[k] = scale_to_q2_14(num[k], norm_sq);
      return m;
   endfunction

   task automatic compare_field(string name, logic [ENT_W-1:0] exp_val,
                                logic [ENT_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name,
                $signed(exp_val), $signed(act_val));
         fail_count++;
      end
   endtask

   string       ent_names [NUM_ENT] = '{"m00", "m01", "m02", "m10", "m11",
                                       "m12", "m20", "m21", "m22"};
   qrm_ent_type observed [NUM_ENT];
   assign observed = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11,
                       rsp_m12, rsp_m20, rsp_m21, rsp_m22};

   // Result side first, so a stray result never pairs with a same-cycle request
   always @(posedge clock) begin
      rot_matrix_type exp_m;
      if (reset) begin
         expected_matrices.delete();
         pending <= 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_matrices.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               exp_m = expected_matrices.pop_front();
               foreach (observed[k]) compare_field(ent_names[k], exp_m.ent[k], observed[k]);
               compare_field("zero_quat", ENT_W'(exp_m.zero), ENT_W'(rsp_zero_quat));
               matrices_checked <= matrices_checked + 1;
            end
         end
         if (start && !busy)
            expected_matrices.push_back(rotation_from_quat(req_quat_w, req_quat_x,
                                                           req_quat_y, req_quat_z));
         pending <= expected_matrices.size();
      end
   end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives quaternions into the rotation matrix block: a directed set of axis
// extremes, zero and small-magnitude cases, then random requests under three
// sender idling profiles. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qrm_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int PHASE_ITEMS  = 400;
   localparam int CYCLE_LIMIT  = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   qrm_quat_type req_quat_w = '0;
   qrm_quat_type req_quat_x = '0;
   qrm_quat_type req_quat_y = '0;
   qrm_quat_type req_quat_z = '0;
   logic         rsp_valid;
   qrm_ent_type  rsp_m00, rsp_m01, rsp_m02;
   qrm_ent_type  rsp_m10, rsp_m11, rsp_m12;
   qrm_ent_type  rsp_m20, rsp_m21, rsp_m22;
   logic         rsp_zero_quat;

   int fail_count;
   int pending;
   int matrices_checked;
   int requests_sent = 0;
   int zero_requests = 0;
   int cycle_count   = 0;

   always #2 clock = ~clock;

   quaternion_to_rotation_matrix_top DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .rsp_valid     (rsp_valid),
      .rsp_m00       (rsp_m00),
      .rsp_m01       (rsp_m01),
      .rsp_m02       (rsp_m02),
      .rsp_m10       (rsp_m10),
      .rsp_m11       (rsp_m11),
      .rsp_m12       (rsp_m12),
      .rsp_m20       (rsp_m20),
      .rsp_m21       (rsp_m21),
      .rsp_m22       (rsp_m22),
      .rsp_zero_quat (rsp_zero_quat)
   );

   rotation_matrix_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_quat_w       (req_quat_w),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .rsp_valid        (rsp_valid),
      .rsp_m00          (rsp_m00),
      .rsp_m01          (rsp_m01),
      .rsp_m02          (rsp_m02),
      .rsp_m10          (rsp_m10),
      .rsp_m11          (rsp_m11),
      .rsp_m12          (rsp_m12),
      .rsp_m20          (rsp_m20),
      .rsp_m21          (rsp_m21),
      .rsp_m22          (rsp_m22),
      .rsp_zero_quat    (rsp_zero_quat),
      .fail_count       (fail_count),
      .pending          (pending),
      .matrices_checked (matrices_checked)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // One request: optional idle cycles, then hold start until accepted.
   // Called and returns at a falling edge.
   task automatic send_quat(qrm_quat_type w, qrm_quat_type x, qrm_quat_type y,
                            qrm_quat_type z, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      if (w == 0 && x == 0 && y == 0 && z == 0)
         zero_requests++;
      @(negedge clock);
   endtask

   // Random phase: mostly full-range, some tiny, corner and zero quaternions
   task automatic random_phase(int count, int idle_pct);
      qrm_quat_type comp [4];
      int           sel;
      repeat (count) begin
         sel = $urandom_range(99);
         foreach (comp[c]) begin
            if (sel < 70)
               comp[c] = qrm_quat_type'($urandom);
            else if (sel < 85)
               comp[c] = qrm_quat_type'(int'($urandom_range(16)) - 8);
            else if (sel < 95)
               case ($urandom_range(4))
                  0:       comp[c] = -16'sd32768;
                  1:       comp[c] = -16'sd1;
                  2:       comp[c] = 16'sd0;
                  3:       comp[c] = 16'sd1;
                  default: comp[c] = 16'sd32767;
               endcase
            else
               comp[c] = '0;
         end
         send_quat(comp[0], comp[1], comp[2], comp[3], idle_pct);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero quaternion, axis extremes, most negative values
      send_quat(0, 0, 0, 0, 17);
      send_quat(32767, 0, 0, 0, 17);
      send_quat(-32768, 0, 0, 0, 17);
      send_quat(0, 32767, 0, 0, 17);
      send_quat(0, -32768, 0, 0, 17);
      send_quat(0, 0, 32767, 0, 17);
      send_quat(0, 0, -32768, 0, 17);
      send_quat(0, 0, 0, 32767, 17);
      send_quat(0, 0, 0, -32768, 17);
      send_quat(-32768, -32768, -32768, -32768, 17);
      send_quat(32767, 32767, 32767, 32767, 17);
      send_quat(32767, -32768, 32767, -32768, 17);
      // Tiny norms, where rounding decides most entries
      send_quat(1, 0, 0, 0, 17);
      send_quat(0, 0, 0, -1, 17);
      send_quat(1, 1, 1, 1, 17);
      send_quat(-1, 1, -1, 1, 17);
      send_quat(1, 1, 1, 0, 17);
      send_quat(1, 2, 3, 4, 17);
      send_quat(0, 0, 0, 0, 17);
      // Non-unit and half-angle rotations
      send_quat(23170, 23170, 0, 0, 17);
      send_quat(16384, 16384, 16384, 16384, 17);
      send_quat(-3, 5, -7, 11, 17);

      random_phase(PHASE_ITEMS, 17);
      random_phase(PHASE_ITEMS, 87);
      random_phase(PHASE_ITEMS, 0);
      start <= 1'b0;

      // Drain the pipeline, then wait with no requests
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);

      $display("sent %0d quaternions (%0d all-zero) under three sender idle profiles",
               requests_sent, zero_requests);
      $display("compared %0d matrices, %0d mismatching fields", matrices_checked,
               fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
